@@ src/u8u16_pkg.sv @@
// shared types and constants of the utf-8 to utf-16 decoder
`default_nettype none

package u8u16_pkg;

  // result status codes
  localparam logic [1:0] STATUS_DATA = 2'd0;
  localparam logic [1:0] STATUS_END  = 2'd1;
  localparam logic [1:0] STATUS_ERR  = 2'd2;

  // configuration register indexes
  localparam logic CFG_BIG_ENDIAN = 1'b0;
  localparam logic CFG_ADD_BOM    = 1'b1;

  // byte constants
  localparam logic [7:0] BOM_UTF8_0 = 8'hef;
  localparam logic [7:0] BOM_UTF8_1 = 8'hbb;
  localparam logic [7:0] BOM_UTF8_2 = 8'hbf;
  localparam logic [7:0] BOM_HI     = 8'hfe;
  localparam logic [7:0] BOM_LO     = 8'hff;

  // what an item leaves for the back end besides an optional mark
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_UNIT,
    KIND_END,
    KIND_ERR
  } kind_t;

  typedef struct packed {
    logic        has_bom;
    logic        hi_first;
    kind_t       kind;
    logic [15:0] unit;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

endpackage

`default_nettype wire

@@ src/u8u16_in_if.sv @@
// input channel: one utf-8 byte per item
`default_nettype none

interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_string;

  modport source (output valid, output data_byte, output new_string, input ready);
  modport sink   (input valid, input data_byte, input new_string, output ready);
endinterface

`default_nettype wire

@@ src/u8u16_out_if.sv @@
// result channel: one utf-16 byte or status per item
`default_nettype none

interface u8u16_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last_of_run;

  modport source (output valid, output out_byte, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input status, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

@@ src/utf8_to_utf16_decoder_core.sv @@
// top level of the utf-8 to utf-16 decoder
// first result of an item passes through the queue and then the output register
// throughput: 1 input item per cycle while the item queue has room; the back
//   end sends 1 result per cycle while the output is ready; an item yields
//   0 to 4 results (mark 2, code unit 2, end or error 1); output sets the rate
// reset: synchronous active-low rst_n clears the config bits, returns the
//   decoder to the start-of-string state and empties the queue and output
`default_nettype none

module utf8_to_utf16_decoder_core #(
  parameter int QUEUE_DEPTH = 4   // classified items held between front and back, 2..16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  u8u16_in_if.sink     in_ch,
  u8u16_out_if.source  out_ch,
  input  wire logic    cfg_we,
  input  wire logic    cfg_idx,
  input  wire logic    cfg_wdata
);
  import u8u16_pkg::*;

  // front to queue: one entry per item that has any result
  q_push_t  push;
  // queue to back end
  q_entry_t head;
  logic     q_full;
  logic     q_empty;
  logic     pop;

  // front: decodes the byte stream, holds the config bits
  u8u16_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push)
  );

  // short queue so input and output stall independently
  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: walks each entry into the output register, one result per cycle while the output is ready
  u8u16_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // end and error results always close an item's run
  a_status_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != STATUS_DATA) |-> out_ch.last_of_run)
    else $error("end or error result not marked last");

  // an item pushed into the queue leaves it non-empty
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |=> !q_empty)
    else $error("queue empty after push");

  // back end only retires entries that exist
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ src/u8u16_front.sv @@
// front end: takes utf-8 bytes, tracks sequence state and classifies each item
`default_nettype none

module u8u16_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  u8u16_in_if.sink              in_ch,
  input  wire logic             cfg_we,
  input  wire logic             cfg_idx,
  input  wire logic             cfg_wdata,
  input  wire logic             q_full,
  output u8u16_pkg::q_push_t    push
);
  import u8u16_pkg::*;

  logic        big_endian_r;
  logic        add_bom_r;
  logic [1:0]  bytes_left_r, bytes_left_nxt;
  logic [15:0] code_accum_r, code_accum_nxt;
  logic        at_first_r, at_first_nxt;
  logic        bom_match_r, bom_match_nxt;
  logic        bom_sent_r, bom_sent_nxt;
  logic        error_r, error_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        fresh;
  logic [1:0]  eff_left;
  logic [15:0] eff_accum;
  logic        eff_first, eff_match, eff_sent, eff_err;
  logic        finish;

  assign in_ch.ready = ~q_full;
  assign accept      = in_ch.valid & ~q_full;
  assign b           = in_ch.data_byte;
  assign fresh       = in_ch.new_string;

  // state as seen after an optional new_string restart
  assign eff_left  = fresh ? 2'd0  : bytes_left_r;
  assign eff_accum = fresh ? 16'd0 : code_accum_r;
  assign eff_first = fresh ? 1'b1  : at_first_r;
  assign eff_match = fresh ? 1'b1  : bom_match_r;
  assign eff_sent  = fresh ? 1'b0  : bom_sent_r;
  assign eff_err   = fresh ? 1'b0  : error_r;

  always_comb begin
    bytes_left_nxt   = eff_left;
    code_accum_nxt   = eff_accum;
    at_first_nxt     = eff_first;
    bom_match_nxt    = eff_match;
    bom_sent_nxt     = eff_sent;
    error_nxt        = eff_err;
    finish           = 1'b0;
    push.entry.has_bom  = 1'b0;
    push.entry.hi_first = big_endian_r;
    push.entry.kind     = KIND_NONE;
    push.entry.unit     = 16'd0;

    if (!eff_err) begin
      push.entry.has_bom = ~eff_sent & add_bom_r;
      bom_sent_nxt       = 1'b1;
      if (b == 8'd0) begin
        push.entry.kind = KIND_END;
        bytes_left_nxt  = 2'd0;
        code_accum_nxt  = 16'd0;
        at_first_nxt    = 1'b1;
        bom_match_nxt   = 1'b1;
        bom_sent_nxt    = 1'b0;
      end else if (eff_left != 2'd0) begin
        if (eff_first) begin
          bom_match_nxt = eff_match &
                          (b == ((eff_left == 2'd2) ? BOM_UTF8_1 : BOM_UTF8_2));
        end
        code_accum_nxt = {eff_accum[9:0], b[5:0]};
        bytes_left_nxt = eff_left - 2'd1;
        finish         = (eff_left == 2'd1);
      end else begin
        if (eff_first) begin
          bom_match_nxt = eff_match & (b == BOM_UTF8_0);
        end
        if (!b[7]) begin
          code_accum_nxt = {8'd0, b};
          finish         = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          code_accum_nxt = {11'd0, b[4:0]};
          bytes_left_nxt = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          code_accum_nxt = {12'd0, b[3:0]};
          bytes_left_nxt = 2'd2;
        end else begin
          // lone continuation or four-plus byte lead
          push.entry.kind = KIND_ERR;
          error_nxt       = 1'b1;
          bytes_left_nxt  = 2'd0;
        end
      end
      if (finish) begin
        at_first_nxt = 1'b0;
        // a leading ef bb bf as the first character is dropped
        if (!(eff_first & bom_match_nxt)) begin
          push.entry.kind = KIND_UNIT;
          push.entry.unit = code_accum_nxt;
        end
      end
    end
    push.valid = accept & (push.entry.has_bom | (push.entry.kind != KIND_NONE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
      add_bom_r    <= 1'b0;
      bytes_left_r <= 2'd0;
      code_accum_r <= 16'd0;
      at_first_r   <= 1'b1;
      bom_match_r  <= 1'b1;
      bom_sent_r   <= 1'b0;
      error_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_BIG_ENDIAN: big_endian_r <= cfg_wdata;
          CFG_ADD_BOM:    add_bom_r    <= cfg_wdata;
          default:        ;
        endcase
      end
      if (accept) begin
        bytes_left_r <= bytes_left_nxt;
        code_accum_r <= code_accum_nxt;
        at_first_r   <= at_first_nxt;
        bom_match_r  <= bom_match_nxt;
        bom_sent_r   <= bom_sent_nxt;
        error_r      <= error_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/u8u16_queue.sv @@
// small fifo of classified items between front and back end
`default_nettype none

module u8u16_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire u8u16_pkg::q_push_t  push,
  input  wire logic                pop,
  output u8u16_pkg::q_entry_t      head,
  output logic                     full,
  output logic                     empty
);
  import u8u16_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  q_entry_t      mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push.valid & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/u8u16_back.sv @@
// back end: serializes each queued item into output bytes behind an output register
`default_nettype none

module u8u16_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire u8u16_pkg::q_entry_t head,
  input  wire logic                q_empty,
  output logic                     pop,
  u8u16_out_if.source              out_ch
);
  import u8u16_pkg::*;

  logic [1:0] step_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic [1:0] status_r;
  logic       last_r;

  logic       advance;
  logic [1:0] s;
  logic [2:0] total;
  logic       is_last;
  logic [7:0] byte_nxt;
  logic [1:0] status_nxt;

  assign advance = ~q_empty & (~valid_r | out_ch.ready);

  always_comb begin
    total = head.has_bom ? 3'd2 : 3'd0;
    case (head.kind)
      KIND_UNIT: total = total + 3'd2;
      KIND_END:  total = total + 3'd1;
      KIND_ERR:  total = total + 3'd1;
      default:   total = total;
    endcase
    is_last    = ({1'b0, step_r} + 3'd1) == total;
    s          = head.has_bom ? step_r - 2'd2 : step_r;
    byte_nxt   = 8'd0;
    status_nxt = STATUS_DATA;
    if (head.has_bom && !step_r[1]) begin
      // byte order mark, fe ff in big endian order
      if (step_r[0] == head.hi_first) begin
        byte_nxt = BOM_LO;
      end else begin
        byte_nxt = BOM_HI;
      end
    end else begin
      case (head.kind)
        KIND_UNIT: byte_nxt = (s[0] == head.hi_first) ? head.unit[7:0] : head.unit[15:8];
        KIND_END:  status_nxt = STATUS_END;
        KIND_ERR:  status_nxt = STATUS_ERR;
        default:   byte_nxt = 8'd0;
      endcase
    end
  end

  assign pop = advance & is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 2'd0;
    end else begin
      if (advance) begin
        valid_r <= 1'b1;
        step_r  <= is_last ? 2'd0 : step_r + 2'd1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r   <= byte_nxt;
      status_r <= status_nxt;
      last_r   <= is_last;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.out_byte    = byte_r;
  assign out_ch.status      = status_r;
  assign out_ch.last_of_run = last_r;

endmodule

`default_nettype wire
